[sv/touch_gate_and_backlight_sleep_defines.svh]
// assertion macros for the touch gate and backlight sleep block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TOUCH_GATE_AND_BACKLIGHT_SLEEP_DEFINES_SVH
`define TOUCH_GATE_AND_BACKLIGHT_SLEEP_DEFINES_SVH

// property that holds at every clock edge out of reset
`define TGBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define TGBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TGBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tgbs_pkg.sv]
// types, codes and constants of the touch gate and backlight sleep block
// no dependencies; imported by tgbs_touch and the top level
package tgbs_pkg;

  // field widths
  localparam int unsigned CoordW   = 10;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PctW     = 7;
  localparam int unsigned PwmW     = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgAddrW = 1;

  // default playback lengths
  localparam int unsigned DefSwipeSteps = 12;
  localparam int unsigned DefTapReads   = 3;

  // backlight and timing constants
  localparam logic [PctW-1:0]  MaxPercent   = 7'd100;
  localparam logic [PctW-1:0]  DimFallback  = 7'd5;
  localparam logic [TimeW-1:0] WakeWindowMs = 32'd1000;
  localparam int unsigned      MsPerSec     = 1000;
  localparam int unsigned      DarkDelayS   = 5;

  // pct * 255 / 100 as a multiply by a scaled reciprocal, exact for pct <= 100
  localparam int unsigned PwmShift = 21;
  localparam int unsigned PwmRecip = 5347860;

  // register indexes
  localparam logic [CfgAddrW-1:0] CfgIdleTimeout  = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgAwakePercent = 1'b1;

  typedef enum logic [1:0] {
    CmdPoll  = 2'd0,
    CmdTap   = 2'd1,
    CmdSwipe = 2'd2,
    CmdTick  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [TimeW-1:0]  now_ms;
    logic              panel_down;
    logic [CoordW-1:0] panel_x;
    logic [CoordW-1:0] panel_y;
    logic [CoordW-1:0] x_start;
    logic [CoordW-1:0] y_start;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic              pressed;
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              is_asleep;
    logic [PctW-1:0]   backlight_level;
    logic [PwmW-1:0]   pwm_level;
  } out_item_t;

  // touch seen by one poll, real or played back
  typedef struct packed {
    logic              down;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } touch_t;

  // brightness drive from backlight percent
  function automatic logic [PwmW-1:0] pwm_of(logic [PctW-1:0] pct);
    logic [29:0] prod;
    prod = 30'(pct) * 30'(PwmRecip);
    return prod[PwmShift +: PwmW];
  endfunction

endpackage

[sv/tgbs_touch.sv]
// touch gate: injected tap and swipe playback merged with the panel touch
// depends on tgbs_pkg
module tgbs_touch import tgbs_pkg::*; #(
  parameter int unsigned SwipeSteps = DefSwipeSteps,
  parameter int unsigned TapReads   = DefTapReads
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output touch_t   touch_o
);

  localparam int unsigned SwipeW   = $clog2(SwipeSteps + 1);
  localparam int unsigned TapW     = $clog2(TapReads + 1);
  localparam int unsigned AccW     = CoordW + $clog2(SwipeSteps);
  localparam int unsigned RecipK   = AccW + 4;
  localparam int unsigned ProdW    = AccW + RecipK;
  localparam longint unsigned RecipVal =
    ((64'd1 << RecipK) + SwipeSteps - 1) / SwipeSteps;

  logic [CoordW-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [CoordW-1:0] end_x_q, end_x_d, end_y_q, end_y_d;
  logic [TapW-1:0]   tap_left_q, tap_left_d;
  logic [SwipeW-1:0] swipe_left_q, swipe_left_d;
  logic [AccW-1:0]   acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [CoordW-1:0] mag_x, mag_y;

  // distance between the swipe ends
  function automatic logic [CoordW-1:0] mag_of(logic [CoordW-1:0] from,
                                               logic [CoordW-1:0] to);
    if (to < from) begin
      return from - to;
    end
    return to - from;
  endfunction

  // from + (to - from) * i / steps, truncated toward zero; acc holds |to - from| * i
  function automatic logic [CoordW-1:0] walk_pt(logic [CoordW-1:0] from,
                                                logic [CoordW-1:0] to,
                                                logic [AccW-1:0]   acc);
    logic [ProdW-1:0]  prod;
    logic [CoordW-1:0] quo;
    prod = ProdW'(acc) * ProdW'(RecipVal);
    quo  = prod[RecipK +: CoordW];
    if (to < from) begin
      return from - quo;
    end
    return from + quo;
  endfunction

  assign mag_x = mag_of(start_x_q, end_x_q);
  assign mag_y = mag_of(start_y_q, end_y_q);

  // playback selection and injection bookkeeping
  always_comb begin
    start_x_d    = start_x_q;
    start_y_d    = start_y_q;
    end_x_d      = end_x_q;
    end_y_d      = end_y_q;
    tap_left_d   = tap_left_q;
    swipe_left_d = swipe_left_q;
    acc_x_d      = acc_x_q;
    acc_y_d      = acc_y_q;
    touch_o      = '{down: 1'b0, x: item_i.panel_x, y: item_i.panel_y};
    unique case (item_i.cmd)
      CmdPoll: begin
        priority if (item_i.panel_down) begin
          touch_o.down = 1'b1;
        end else if (swipe_left_q != '0) begin
          touch_o.down = 1'b1;
          touch_o.x    = walk_pt(start_x_q, end_x_q, acc_x_q);
          touch_o.y    = walk_pt(start_y_q, end_y_q, acc_y_q);
          swipe_left_d = swipe_left_q - SwipeW'(1);
          acc_x_d      = acc_x_q + AccW'(mag_x);
          acc_y_d      = acc_y_q + AccW'(mag_y);
        end else if (tap_left_q != '0) begin
          touch_o.down = 1'b1;
          touch_o.x    = start_x_q;
          touch_o.y    = start_y_q;
          tap_left_d   = tap_left_q - TapW'(1);
        end
      end
      CmdTap: begin
        start_x_d    = item_i.x_start;
        start_y_d    = item_i.y_start;
        swipe_left_d = '0;
        tap_left_d   = TapW'(TapReads);
      end
      CmdSwipe: begin
        start_x_d    = item_i.x_start;
        start_y_d    = item_i.y_start;
        end_x_d      = item_i.x_end;
        end_y_d      = item_i.y_end;
        tap_left_d   = '0;
        swipe_left_d = SwipeW'(SwipeSteps);
        acc_x_d      = '0;
        acc_y_d      = '0;
      end
      CmdTick: begin
      end
    endcase
  end

  // playback state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q    <= '0;
      start_y_q    <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      tap_left_q   <= '0;
      swipe_left_q <= '0;
      acc_x_q      <= '0;
      acc_y_q      <= '0;
    end else if (step_i) begin
      start_x_q    <= start_x_d;
      start_y_q    <= start_y_d;
      end_x_q      <= end_x_d;
      end_y_q      <= end_y_d;
      tap_left_q   <= tap_left_d;
      swipe_left_q <= swipe_left_d;
      acc_x_q      <= acc_x_d;
      acc_y_q      <= acc_y_d;
    end
  end

endmodule

[sv/touch_gate_and_backlight_sleep.sv]
// top level: input register, touch gate, sleep and backlight control, result register
// depends on tgbs_pkg, tgbs_touch and touch_gate_and_backlight_sleep_defines.svh
//
//   channel | signals                           | transfer
//   --------+-----------------------------------+------------------------------
//   input   | in_valid_i  in_ready_o  in_data_i | in_valid_i and in_ready_o
//   output  | out_valid_o out_ready_i out_data_o| out_valid_o and out_ready_i
//   config  | cfg_we_i cfg_addr_i cfg_wdata_i   | cfg_we_i, no wait
//
// one item per cycle while the output is not stalled; an item passes through the input register
// and then the result register, and its result is offered from the result register
// all state updates for an item happen in the single cycle it leaves the input register
// a stalled output holds the result register and then the input register, no item is lost
// reset clears control and sleep state; no clearing pass, items are taken right after reset
`include "touch_gate_and_backlight_sleep_defines.svh"

module touch_gate_and_backlight_sleep import tgbs_pkg::*; #(
  parameter int unsigned SwipeSteps = DefSwipeSteps,
  parameter int unsigned TapReads   = DefTapReads
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o
);

  localparam int unsigned DimMsW  = TimeoutW + $clog2(MsPerSec);
  localparam int unsigned DarkMsW = DimMsW + 1;

  in_item_t  s1_q;
  logic      s1_valid_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic      adv;
  touch_t    touch;

  logic [TimeoutW-1:0] timeout_q;
  logic [PctW-1:0]     awake_q;
  logic [DimMsW-1:0]   dim_ms_q;
  logic [DarkMsW-1:0]  dark_ms_q;

  logic [TimeW-1:0] last_q, last_d;
  logic             tv_q, tv_d;
  logic             sleeping_q, sleeping_d;
  logic [PctW-1:0]  pct_q, pct_d;
  logic [TimeW-1:0] last_eff, elapsed;
  logic [PctW-1:0]  awake_lvl, dim_lvl;

  // pipeline handshake
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  // configuration, thresholds in ms computed at write time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= '0;
      awake_q   <= MaxPercent;
      dim_ms_q  <= '0;
      dark_ms_q <= DarkMsW'(DarkDelayS * MsPerSec);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgIdleTimeout: begin
          timeout_q <= cfg_wdata_i[TimeoutW-1:0];
          dim_ms_q  <= DimMsW'(cfg_wdata_i[TimeoutW-1:0]) * DimMsW'(MsPerSec);
          dark_ms_q <= DarkMsW'(DarkMsW'(cfg_wdata_i[TimeoutW-1:0]) + DarkMsW'(DarkDelayS))
                       * DarkMsW'(MsPerSec);
        end
        CfgAwakePercent: begin
          awake_q <= cfg_wdata_i[PctW-1:0];
        end
      endcase
    end
  end

  // touch gate and playback
  tgbs_touch #(
    .SwipeSteps(SwipeSteps),
    .TapReads  (TapReads)
  ) u_touch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (s1_q),
    .touch_o(touch)
  );

  // backlight levels
  assign awake_lvl = (awake_q > MaxPercent) ? MaxPercent : awake_q;
  assign dim_lvl   = (awake_q[PctW-1:2] == '0) ? DimFallback : PctW'(awake_q[PctW-1:2]);

  // last touch stamp and sleep control
  always_comb begin
    last_d     = last_q;
    tv_d       = tv_q;
    sleeping_d = sleeping_q;
    pct_d      = pct_q;
    last_eff   = tv_q ? last_q : s1_q.now_ms;
    elapsed    = s1_q.now_ms - last_eff;
    unique case (s1_q.cmd)
      CmdPoll: begin
        if (touch.down) begin
          last_d = s1_q.now_ms;
          tv_d   = 1'b1;
        end
      end
      CmdTick: begin
        if (!tv_q) begin
          last_d = s1_q.now_ms;
          tv_d   = 1'b1;
        end
        priority if (timeout_q == '0) begin
          if (sleeping_q) begin
            sleeping_d = 1'b0;
            pct_d      = awake_lvl;
          end
        end else if (sleeping_q) begin
          if (elapsed < WakeWindowMs) begin
            sleeping_d = 1'b0;
            pct_d      = awake_lvl;
          end
        end else if (elapsed >= TimeW'(dark_ms_q)) begin
          sleeping_d = 1'b1;
          pct_d      = '0;
        end else if (elapsed >= TimeW'(dim_ms_q)) begin
          pct_d = dim_lvl;
        end else if (pct_q != awake_q) begin
          pct_d = awake_lvl;
        end
      end
      CmdTap, CmdSwipe: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      tv_q       <= 1'b0;
      sleeping_q <= 1'b0;
      pct_q      <= MaxPercent;
    end else if (adv) begin
      last_q     <= last_d;
      tv_q       <= tv_d;
      sleeping_q <= sleeping_d;
      pct_q      <= pct_d;
    end
  end

  // result assembly
  always_comb begin
    out_d.pressed         = (s1_q.cmd == CmdPoll) && touch.down && !sleeping_q;
    out_d.point_x         = out_d.pressed ? touch.x : '0;
    out_d.point_y         = out_d.pressed ? touch.y : '0;
    out_d.is_asleep       = sleeping_d;
    out_d.backlight_level = pct_d;
    out_d.pwm_level       = pwm_of(pct_d);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `TGBS_ASSERT(PctInRange_A, pct_q <= MaxPercent, "backlight percent above full scale")
  `TGBS_ASSERT_IMP(AsleepIsDark_A, sleeping_q, pct_q == '0, "asleep with backlight on")
  `TGBS_ASSERT_IMP(PressedAwake_A, out_valid_o && out_data_o.pressed, !out_data_o.is_asleep, "press reported while asleep")
  `TGBS_ASSERT_NEXT(AdvFills_A, adv, out_valid_q, "processed item did not reach the result register")

endmodule
